// ===== src/cbba_pkg.sv =====
// Shared types and constants for the contiguous bitmap block allocator.
`default_nettype none

package cbba_pkg;

  localparam int LENGTH_W      = 32;
  localparam int BLOCK_INDEX_W = 12;
  localparam int STATUS_W      = 2;
  localparam int OFFSET_W      = 21;
  localparam int TAKEN_W       = 13;
  localparam int SLOT_W        = 5;
  localparam int FREE_W        = 13;
  localparam int ACC_W         = LENGTH_W + 1;

  localparam int FIRST_DATA_BLOCK = 4;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_LOAD  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUN   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIR_FULL = 2'd2;

  typedef struct packed {
    logic                     action;
    logic [LENGTH_W-1:0]      length_bytes;
    logic [BLOCK_INDEX_W-1:0] block_index;
    logic                     block_is_free;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] start_offset;
    logic [TAKEN_W-1:0]  blocks_taken;
    logic [SLOT_W-1:0]   file_slot;
    logic [FREE_W-1:0]   free_blocks;
  } result_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic bit_free;
  } run_ctl_t;

endpackage

`default_nettype wire

// ===== src/cbba_map.sv =====
// Free map memory: one bit per block, one write port, one registered read port.
`default_nettype none

module cbba_map #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/cbba_run_unit.sv =====
// Run tracker: shared adder and compare that follows the current free run.
`default_nettype none

module cbba_run_unit
  import cbba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 4096,
  parameter int BLOCK_BYTES = 512
) (
  input  logic                              clk,
  input  run_ctl_t                          ctl,
  input  logic [$clog2(NUM_BLOCKS)-1:0]     cur_addr,
  input  logic [LENGTH_W-1:0]               length_bytes,
  output logic                              found,
  output logic [$clog2(NUM_BLOCKS)-1:0]     start_sel,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]   run_next
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);

  logic [CW-1:0]    run;
  logic [ACC_W-1:0] acc;
  logic [AW-1:0]    start;
  logic [ACC_W-1:0] acc_sum;

  assign acc_sum   = acc + ACC_W'(BLOCK_BYTES);
  assign run_next  = run + CW'(1);
  assign start_sel = (run == '0) ? cur_addr : start;
  assign found     = ctl.step && ctl.bit_free && (acc_sum >= {1'b0, length_bytes});

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      run <= '0;
      acc <= '0;
    end else if (ctl.step) begin
      if (ctl.bit_free) begin
        run   <= run_next;
        acc   <= acc_sum;
        start <= start_sel;
      end else begin
        run <= '0;
        acc <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/contiguous_bitmap_block_allocator.sv =====
// Top level: sequencer over the free map and run tracker of the block allocator.
// After reset the block sweeps the free map once, one block per cycle, and holds busy
// high meanwhile. A request is taken when start is high and busy is low; every request
// gives exactly one result, shown for one cycle with done high, and the receiver cannot
// stall it. A load reads the map bit of its block, then writes it if it changes and
// answers; an index out of range is answered at once. An allocate scans the map
// first-fit from block 4, one block per cycle through the single read port of the map,
// then marks the run one block per cycle; zero length and full directory are answered
// at once.
`default_nettype none

module contiguous_bitmap_block_allocator
  import cbba_pkg::*;
#(
  parameter int NUM_BLOCKS  = 4096,
  parameter int BLOCK_BYTES = 512,
  parameter int MAX_FILES   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int SW = AW + 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int FW = $clog2(MAX_FILES + 1);
  localparam int BW = $clog2(BLOCK_BYTES + 1);
  localparam int PW = AW + BW;
  localparam int IW = (AW > BLOCK_INDEX_W) ? AW : BLOCK_INDEX_W;

  localparam logic [IW:0] NB_LIMIT = (IW + 1)'(NUM_BLOCKS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LCHK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_MARK  = 3'd4;

  logic [2:0]    state;
  logic [AW-1:0] clr_addr;
  logic [SW-1:0] scan_addr;
  logic [AW-1:0] mark_addr;
  logic [CW-1:0] mark_left;
  logic [CW-1:0] need;
  logic [AW-1:0] start_q;
  logic [AW-1:0] load_addr;
  logic          load_bit;
  logic [CW-1:0] free_count;
  logic [FW-1:0] file_count;
  logic [LENGTH_W-1:0] request_len_q;

  logic [IW-1:0] idx_ext;
  logic          idx_in_range;
  logic [SW-1:0] cur_full;
  logic          scan_last;
  logic [CW-1:0] count_load;
  logic [CW-1:0] count_alloc;
  logic [PW-1:0] offset_full;

  logic          map_we;
  logic [AW-1:0] map_waddr;
  logic          map_wdata;
  logic [AW-1:0] map_raddr;
  logic          map_rdata;

  run_ctl_t      run_ctl;
  logic          run_found;
  logic [AW-1:0] run_start;
  logic [CW-1:0] run_next;

  function automatic result_t make_result(
    input logic [STATUS_W-1:0] status,
    input logic [OFFSET_W-1:0] offset,
    input logic [TAKEN_W-1:0]  taken,
    input logic [SLOT_W-1:0]   slot,
    input logic [FREE_W-1:0]   free
  );
    result_t r;
    r.status       = status;
    r.start_offset = offset;
    r.blocks_taken = taken;
    r.file_slot    = slot;
    r.free_blocks  = free;
    return r;
  endfunction

  assign busy         = (state != S_IDLE);
  assign idx_ext      = IW'(request.block_index);
  assign idx_in_range = ({1'b0, idx_ext} < NB_LIMIT);
  assign cur_full     = scan_addr - SW'(1);
  assign scan_last    = (cur_full == SW'(NUM_BLOCKS - 1));
  assign offset_full  = PW'(start_q) * PW'(BLOCK_BYTES);
  assign count_alloc  = (free_count >= need) ? (free_count - need) : '0;

  always_comb begin
    count_load = free_count;
    if (map_rdata != load_bit) begin
      if (load_bit) begin
        count_load = free_count + CW'(1);
      end else if (free_count != '0) begin
        count_load = free_count - CW'(1);
      end
    end
  end

  always_comb begin
    map_we           = 1'b0;
    map_waddr        = clr_addr;
    map_wdata        = 1'b0;
    map_raddr        = scan_addr[AW-1:0];
    run_ctl          = '0;
    run_ctl.bit_free = map_rdata;
    case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = (clr_addr >= AW'(FIRST_DATA_BLOCK));
      end
      S_IDLE: begin
        run_ctl.clear = 1'b1;
        map_raddr     = (request.action == ACTION_LOAD) ? idx_ext[AW-1:0]
                                                        : AW'(FIRST_DATA_BLOCK);
      end
      S_LCHK: begin
        map_we    = (map_rdata != load_bit);
        map_waddr = load_addr;
        map_wdata = load_bit;
      end
      S_SCAN: begin
        run_ctl.step = 1'b1;
      end
      S_MARK: begin
        map_we    = 1'b1;
        map_waddr = mark_addr;
        map_wdata = 1'b0;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      free_count <= CW'(NUM_BLOCKS - FIRST_DATA_BLOCK);
      file_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(NUM_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            load_addr <= idx_ext[AW-1:0];
            load_bit  <= request.block_is_free;
            if (request.action == ACTION_LOAD) begin
              if (idx_in_range) begin
                state <= S_LCHK;
              end else begin
                done   <= 1'b1;
                result <= make_result(STATUS_OK, '0, '0, '0, FREE_W'(free_count));
              end
            end else if (request.length_bytes == '0) begin
              done   <= 1'b1;
              result <= make_result(STATUS_NO_RUN, '0, '0, '0, FREE_W'(free_count));
            end else if (file_count >= FW'(MAX_FILES)) begin
              done   <= 1'b1;
              result <= make_result(STATUS_DIR_FULL, '0, '0, '0, FREE_W'(free_count));
            end else begin
              scan_addr <= SW'(FIRST_DATA_BLOCK + 1);
              state     <= S_SCAN;
            end
          end
        end
        S_LCHK: begin
          free_count <= count_load;
          done       <= 1'b1;
          result     <= make_result(STATUS_OK, '0, '0, '0, FREE_W'(count_load));
          state      <= S_IDLE;
        end
        S_SCAN: begin
          if (run_found) begin
            mark_addr <= run_start;
            start_q   <= run_start;
            mark_left <= run_next;
            need      <= run_next;
            state     <= S_MARK;
          end else if (scan_last) begin
            done   <= 1'b1;
            result <= make_result(STATUS_NO_RUN, '0, '0, '0, FREE_W'(free_count));
            state  <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + SW'(1);
          end
        end
        S_MARK: begin
          mark_addr <= mark_addr + AW'(1);
          mark_left <= mark_left - CW'(1);
          if (mark_left == CW'(1)) begin
            free_count <= count_alloc;
            file_count <= file_count + FW'(1);
            done       <= 1'b1;
            result     <= make_result(STATUS_OK, OFFSET_W'(offset_full), TAKEN_W'(need),
                                      SLOT_W'(file_count), FREE_W'(count_alloc));
            state      <= S_IDLE;
          end
        end
        default: begin
          state    <= S_CLEAR;
          clr_addr <= '0;
        end
      endcase
    end
  end

  cbba_map #(
    .DEPTH (NUM_BLOCKS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  cbba_run_unit #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_run (
    .clk          (clk),
    .ctl          (run_ctl),
    .cur_addr     (cur_full[AW-1:0]),
    .length_bytes (request_len_q),
    .found        (run_found),
    .start_sel    (run_start),
    .run_next     (run_next)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      request_len_q <= request.length_bytes;
    end
  end

  a_free_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(NUM_BLOCKS))
    else $error("free count above number of blocks");

  a_file_count_bound: assert property (@(posedge clk) disable iff (rst)
    file_count <= FW'(MAX_FILES))
    else $error("file count above directory size");

  a_mark_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK |-> mark_left != '0)
    else $error("mark pass with no blocks left");

  a_request_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request neither in progress nor answered");

endmodule

`default_nettype wire
